FILE: rtl/bir_pkg.sv
// Shared types and constants for the biquad integer resampler.
// Used by bir_biquad_dp and biquad_integer_resampler; depends on nothing.
package bir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int FACTOR_W = 5;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_MAX_FACTOR     = 16;
  localparam int DEF_COEF_FRAC_BITS = 16;

  localparam logic                     RST_MODE   = 1'b0;
  localparam logic [FACTOR_W-1:0]      RST_FACTOR = 5'd2;
  localparam logic signed [COEF_W-1:0] RST_B0     = 18'sd28424;
  localparam logic signed [COEF_W-1:0] RST_A1     = 18'sd33809;
  localparam logic signed [COEF_W-1:0] RST_A2     = 18'sd14354;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_FACTOR = 3'd1,
    CFG_B0     = 3'd2,
    CFG_A1     = 3'd3,
    CFG_A2     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_UPSAMPLE = 1'b0,
    MODE_DECIMATE = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       stream_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       run_last;
    logic                       stream_end;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

endpackage

FILE: rtl/bir_biquad_dp.sv
// One biquad step: y = b0*(x0 + 2*x1 + x2) - a1*y1 - a2*y2, rounded and saturated.
// Purely combinational; depends on bir_pkg.
module bir_biquad_dp import bir_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  coef_t                      coef_i,
  input  logic signed [SAMPLE_W-1:0] x0_i,
  input  logic signed [SAMPLE_W-1:0] x1_i,
  input  logic signed [SAMPLE_W-1:0] x2_i,
  input  logic signed [SAMPLE_W-1:0] y1_i,
  input  logic signed [SAMPLE_W-1:0] y2_i,
  output logic signed [SAMPLE_W-1:0] y_o
);

  localparam int SUM_W  = SAMPLE_W + 3;
  localparam int FFP_W  = COEF_W + SUM_W;
  localparam int FBP_W  = COEF_W + SAMPLE_W;
  localparam int ACC_W  = FFP_W + 3;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic signed [SUM_W-1:0] ff_sum;
  logic signed [FFP_W-1:0] ff_prod;
  logic signed [FBP_W-1:0] fb1_prod;
  logic signed [FBP_W-1:0] fb2_prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] scaled;

  // b0, 2*b0 and b0 share one multiply over the summed taps
  assign ff_sum   = SUM_W'(x0_i) + SUM_W'(x1_i) + SUM_W'(x1_i) + SUM_W'(x2_i);
  assign ff_prod  = FFP_W'(coef_i.b0) * FFP_W'(ff_sum);
  assign fb1_prod = FBP_W'(coef_i.a1) * FBP_W'(y1_i);
  assign fb2_prod = FBP_W'(coef_i.a2) * FBP_W'(y2_i);

  assign acc    = ACC_W'(ff_prod) - ACC_W'(fb1_prod) - ACC_W'(fb2_prod) + RND;
  assign scaled = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (scaled > SAT_HI) begin
      y_o = 16'sh7FFF;
    end else if (scaled < SAT_LO) begin
      y_o = -16'sh8000;
    end else begin
      y_o = scaled[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: rtl/biquad_integer_resampler.sv
// Top level of the integer-factor resampler with a Butterworth biquad low-pass.
// Depends on bir_pkg and bir_biquad_dp.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+------------------------------
//   in      | sink      | in_valid_i/in_stall_o | in_item_t  (sample, last flag)
//   out     | source    | out_valid_o/out_stall_i | out_item_t (sample, flags)
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | register index + data
//
// Upsample mode: an input beat takes as many filter steps as the factor, one step and
// one output beat per cycle unless stalled; the output delay feedback sets this rate.
// Decimate mode: one filter step per input beat, an output beat every factor inputs.
// The next input beat is taken in the cycle its predecessor finishes its last step.
// Reset clears the filter delays, the phase and all valid flags; the config
// registers return to a Butterworth low-pass at half rate, factor 2, upsample.
// A stall while a result is held keeps the result register and freezes the filter steps.
module biquad_integer_resampler import bir_pkg::*; #(
  parameter int MAX_FACTOR     = DEF_MAX_FACTOR,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  localparam int STEP_W = $clog2(MAX_FACTOR);
  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int CW     = (FW > FACTOR_W) ? FW : FACTOR_W;
  localparam logic [CW-1:0] MAX_F = CW'(MAX_FACTOR);

  // Configuration registers
  mode_e               mode_q;
  logic [FACTOR_W-1:0] factor_q;
  coef_t               coef_q;

  // Item register and step counter
  in_item_t            item_q;
  logic                item_vld_q;
  logic [STEP_W-1:0]   step_q;

  // Filter state
  logic signed [SAMPLE_W-1:0] x1_q, x2_q, y1_q, y2_q;
  logic [STEP_W-1:0]          phase_q;

  // Result register
  out_item_t out_q;
  logic      out_vld_q;

  logic [CW-1:0]              factor_eff;
  logic [CW-1:0]              step_next;
  logic [CW-1:0]              phase_next;
  logic                       step_fin;
  logic                       out_free;
  logic                       step_en;
  logic                       emit;
  logic                       in_take;
  logic signed [SAMPLE_W-1:0] x0;
  logic signed [SAMPLE_W-1:0] y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_UPSAMPLE;
      factor_q  <= RST_FACTOR;
      coef_q.b0 <= RST_B0;
      coef_q.a1 <= RST_A1;
      coef_q.a2 <= RST_A2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:   mode_q    <= mode_e'(cfg_data_i[0]);
        CFG_FACTOR: factor_q  <= cfg_data_i[FACTOR_W-1:0];
        CFG_B0:     coef_q.b0 <= $signed(cfg_data_i);
        CFG_A1:     coef_q.a1 <= $signed(cfg_data_i);
        CFG_A2:     coef_q.a2 <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp the factor: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (factor_q == '0) begin
      factor_eff = CW'(1);
    end else if (CW'(factor_q) > MAX_F) begin
      factor_eff = MAX_F;
    end else begin
      factor_eff = CW'(factor_q);
    end
  end

  assign step_next  = CW'(step_q) + CW'(1);
  assign phase_next = (CW'(phase_q) + CW'(1) >= factor_eff) ? '0 : CW'(phase_q) + CW'(1);

  // Decimate mode is always a single step per item
  assign step_fin = (mode_q == MODE_DECIMATE) || (step_next == factor_eff);
  assign emit     = (mode_q == MODE_UPSAMPLE) || (phase_q == '0);
  assign out_free = !out_vld_q || !out_stall_i;
  assign step_en  = item_vld_q && out_free;

  // Zero-stuff every step after the first in upsample mode
  assign x0 = ((mode_q == MODE_UPSAMPLE) && (step_q != '0)) ? '0 : item_q.sample_in;

  bir_biquad_dp #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .coef_i (coef_q),
    .x0_i   (x0),
    .x1_i   (x1_q),
    .x2_i   (x2_q),
    .y1_i   (y1_q),
    .y2_i   (y2_q),
    .y_o    (y)
  );

  // Accept a new beat when empty or when the held item finishes this cycle
  assign in_stall_o = item_vld_q && !(step_en && step_fin);
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      step_q     <= '0;
    end else if (in_take) begin
      item_vld_q <= 1'b1;
      step_q     <= '0;
    end else if (step_en) begin
      if (step_fin) begin
        item_vld_q <= 1'b0;
        step_q     <= '0;
      end else begin
        step_q <= step_next[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Advance the delay line; drop all history after a last-flagged item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q    <= '0;
      x2_q    <= '0;
      y1_q    <= '0;
      y2_q    <= '0;
      phase_q <= '0;
    end else if (step_en) begin
      if (step_fin && item_q.stream_last) begin
        x1_q    <= '0;
        x2_q    <= '0;
        y1_q    <= '0;
        y2_q    <= '0;
        phase_q <= '0;
      end else begin
        x1_q <= x0;
        x2_q <= x1_q;
        y1_q <= y;
        y2_q <= y1_q;
        if (mode_q == MODE_DECIMATE) begin
          phase_q <= phase_next[STEP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_en && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && emit) begin
      out_q.sample_out <= y;
      out_q.run_last   <= step_fin;
      out_q.stream_end <= step_fin && item_q.stream_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A beat is taken over a busy item only as that item finishes
  a_take_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && item_vld_q) |-> (step_en && step_fin))
    else $error("input beat taken while item still has steps left");

  // History is gone right after the final step of a last-flagged item
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && step_fin && item_q.stream_last) |=>
      (x1_q == '0 && x2_q == '0 && y1_q == '0 && y2_q == '0 && phase_q == '0))
    else $error("filter state not cleared after stream end");

  // End of stream only ever marks the last result of an item
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.stream_end || out_q.run_last))
    else $error("stream_end without run_last");

  // A new result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> ($stable(out_q) && out_vld_q))
    else $error("stalled result overwritten");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for biquad_integer_resampler: directed and random streams.
// Depends on bir_pkg and the RTL. Holds its own filter predictor; results are
// checked beat by beat.
`timescale 1ns / 100ps

module tb_top;
  import bir_pkg::*;

  // Let a stream fully settle: the longest upsample run plus margin.
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_FACTOR + 8;
  localparam int DRAIN_GUARD   = 20000;
  localparam int MAX_PRINTS    = 40;

  localparam logic signed [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
  logic [COEF_W-1:0]    cfg_data  = '0;

  // Shadow of the configuration registers.
  mode_e                    mdl_mode   = mode_e'(RST_MODE);
  logic [FACTOR_W-1:0]      mdl_factor = RST_FACTOR;
  logic signed [COEF_W-1:0] mdl_b0     = RST_B0;
  logic signed [COEF_W-1:0] mdl_a1     = RST_A1;
  logic signed [COEF_W-1:0] mdl_a2     = RST_A2;

  // Filter history and decimation phase.
  logic signed [SAMPLE_W-1:0] hist_x1   = '0;
  logic signed [SAMPLE_W-1:0] hist_x2   = '0;
  logic signed [SAMPLE_W-1:0] hist_y1   = '0;
  logic signed [SAMPLE_W-1:0] hist_y2   = '0;
  logic [3:0]                 dec_phase = '0;

  out_item_t due_samples[$];
  int        fail_count = 0;
  bit        gaps_on    = 1'b1;
  bit        stall_on   = 1'b1;

  biquad_integer_resampler #(
    .MAX_FACTOR    (DEF_MAX_FACTOR),
    .COEF_FRAC_BITS(DEF_COEF_FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // One filter step: exact products, round half up, floor shift, saturate.
  function automatic logic signed [SAMPLE_W-1:0] biquad_tick(
    input logic signed [SAMPLE_W-1:0] x0);
    longint acc;
    longint y;
    acc = longint'(mdl_b0) * longint'(x0)
        + 2 * longint'(mdl_b0) * longint'(hist_x1)
        + longint'(mdl_b0) * longint'(hist_x2)
        - longint'(mdl_a1) * longint'(hist_y1)
        - longint'(mdl_a2) * longint'(hist_y2);
    acc += longint'(1) <<< (DEF_COEF_FRAC_BITS - 1);
    y = acc >>> DEF_COEF_FRAC_BITS;
    if (y > longint'(SMP_MAX)) y = longint'(SMP_MAX);
    if (y < longint'(SMP_MIN)) y = longint'(SMP_MIN);
    hist_x2 = hist_x1;
    hist_x1 = x0;
    hist_y2 = hist_y1;
    hist_y1 = SAMPLE_W'(y);
    return SAMPLE_W'(y);
  endfunction

  // Work out the output beats one accepted input beat causes.
  task automatic resample_predict(input in_item_t beat);
    int unsigned                f;
    int unsigned                nxt;
    logic signed [SAMPLE_W-1:0] x;
    out_item_t                  r;
    f = mdl_factor;
    if (f == 0) f = 1;
    if (f > DEF_MAX_FACTOR) f = DEF_MAX_FACTOR;
    if (mdl_mode == MODE_UPSAMPLE) begin
      for (int unsigned i = 0; i < f; i++) begin
        x = (i == 0) ? beat.sample_in : SMP_MAX ^ SMP_MAX;
        r.sample_out = biquad_tick(x);
        r.run_last   = (i + 1 == f);
        r.stream_end = (i + 1 == f) && beat.stream_last;
        due_samples.push_back(r);
      end
    end else begin
      r.sample_out = biquad_tick(beat.sample_in);
      nxt = dec_phase + 1;
      if (dec_phase == 0) begin
        r.run_last   = 1'b1;
        r.stream_end = beat.stream_last;
        due_samples.push_back(r);
      end
      if (nxt >= f) nxt = 0;
      dec_phase = 4'(nxt);
    end
    // Clear the history at the end of a stream.
    if (beat.stream_last) begin
      hist_x1   = '0;
      hist_x2   = '0;
      hist_y1   = '0;
      hist_y2   = '0;
      dec_phase = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // Send one input beat, after an optional idle gap; hold it until taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic lst);
    int       gap;
    in_item_t beat;
    beat.sample_in   = value;
    beat.stream_last = lst;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    resample_predict(beat);
  endtask

  // Drop valid and hold off until every due beat has come, then settle.
  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    @(negedge clk) in_valid <= 1'b0;
    while (due_samples.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (due_samples.size() != 0) begin
      flag_mismatch($sformatf("%0d output beats never arrived", due_samples.size()));
      due_samples.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_MODE:   mdl_mode   = mode_e'(val[0]);
      CFG_FACTOR: mdl_factor = val[FACTOR_W-1:0];
      CFG_B0:     mdl_b0     = val;
      CFG_A1:     mdl_a1     = val;
      CFG_A2:     mdl_a2     = val;
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_rate(input mode_e m, input int unsigned f);
    write_reg(CFG_MODE, COEF_W'(m));
    write_reg(CFG_FACTOR, COEF_W'(f));
  endtask

  task automatic set_filter(input logic signed [COEF_W-1:0] b0,
                            input logic signed [COEF_W-1:0] a1,
                            input logic signed [COEF_W-1:0] a2);
    write_reg(CFG_B0, b0);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
  endtask

  // Reset values: upsample by two through the half-rate Butterworth.
  task automatic test_defaults();
    send_sample(SMP_MAX, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(SMP_MIN, 1'b1);
  endtask

  // Extreme samples against extreme coefficients; drive into saturation.
  task automatic test_sample_extremes();
    wait_idle(SETTLE_CYCLES);
    set_filter(COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    wait_idle(SETTLE_CYCLES);
    set_filter(COEF_MIN, COEF_MAX, COEF_MIN);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MAX, 1'b1);
  endtask

  // Factor zero acts as one; factors beyond the maximum clamp to it.
  task automatic test_factor_limits();
    wait_idle(SETTLE_CYCLES);
    set_filter(RST_B0, RST_A1, RST_A2);
    set_rate(MODE_UPSAMPLE, 0);
    send_sample(16'sd20000, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_UPSAMPLE, 1);
    send_sample(-16'sd20000, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_UPSAMPLE, DEF_MAX_FACTOR);
    send_sample(16'sd7777, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_UPSAMPLE, DEF_MAX_FACTOR + 1);
    send_sample(-16'sd4321, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_UPSAMPLE, (1 << FACTOR_W) - 1);
    send_sample(16'sd30000, 1'b1);
  endtask

  // Decimation: last beat on and off phase, and a phase left beyond the factor.
  task automatic test_decimate();
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_DECIMATE, 3);
    send_sample(16'sd1000, 1'b1);
    send_sample(-16'sd2000, 1'b0);
    send_sample(16'sd3000, 1'b1);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_DECIMATE, DEF_MAX_FACTOR);
    send_sample(16'sd15000, 1'b0);
    send_sample(-16'sd15000, 1'b0);
    send_sample(16'sd9000, 1'b0);
    // Phase is now three; shrink the factor below it so it has to wrap.
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_FACTOR, COEF_W'(2));
    send_sample(-16'sd9000, 1'b0);
  endtask

  // Switch modes inside a stream; history carries over. Poke unused indexes.
  task automatic test_mode_change();
    wait_idle(SETTLE_CYCLES);
    for (int i = int'(CFG_A2) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
    set_rate(MODE_UPSAMPLE, 2);
    send_sample(16'sd12345, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_rate(MODE_DECIMATE, 2);
    send_sample(-16'sd12345, 1'b1);
  endtask

  function automatic int unsigned pick_factor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 4);
    if (r < 75) return $urandom_range(5, DEF_MAX_FACTOR - 1);
    if (r < 85) return DEF_MAX_FACTOR;
    if (r < 93) return 0;
    return $urandom_range(DEF_MAX_FACTOR + 1, (1 << FACTOR_W) - 1);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return SAMPLE_W'($urandom);
    if (r < 80) return SAMPLE_W'(int'($urandom_range(0, 256)) - 128);
    if (r < 88) return SMP_MAX;
    if (r < 96) return SMP_MIN;
    return SMP_MAX ^ SMP_MAX;
  endfunction

  // Random streams in phases, each with its own settings and idling habits.
  // Most beats form streams closed by a last beat; a few end early or get
  // cut by a settings change.
  task automatic test_random_streams(input int total);
    int   sent;
    int   left;
    int   r;
    logic lst;
    sent = 0;
    left = 0;
    while (sent < total) begin
      wait_idle(SETTLE_CYCLES);
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      set_rate(mode_e'($urandom_range(0, 1)), pick_factor());
      r = $urandom_range(0, 99);
      if (r < 50) set_filter(RST_B0, RST_A1, RST_A2);
      else if (r < 80) set_filter(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
      else set_filter(COEF_W'(int'($urandom_range(0, 65535)) - 32768),
                      COEF_W'(int'($urandom_range(0, 65535)) - 32768),
                      COEF_W'(int'($urandom_range(0, 65535)) - 32768));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_A2) + 1, (1 << CFG_IDX_W) - 1)),
                  COEF_W'($urandom));
      repeat ($urandom_range(25, 50)) begin
        if (sent >= total) break;
        if (left == 0) left = $urandom_range(1, 24);
        lst = (left == 1) || ($urandom_range(0, 49) == 0);
        send_sample(pick_sample(), lst);
        left = lst ? 0 : left - 1;
        sent++;
        // Hold the sender now and then until the output side catches up.
        if ($urandom_range(0, 59) == 0) wait_idle(0);
      end
    end
  endtask

  // Output stall: free runs, then mostly short and now and then long stalls.
  initial begin
    int len;
    wait (rst_n === 1'b1);
    forever begin
      if (!stall_on) begin
        @(negedge clk) out_stall <= 1'b0;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) @(negedge clk) out_stall <= 1'b0;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        repeat (len) @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  // Compare each taken output beat with the oldest due one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (due_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected output beat, sample %0d", out_data.sample_out));
      end else begin
        want = due_samples.pop_front();
        if (out_data.sample_out !== want.sample_out)
          flag_mismatch($sformatf("sample_out %0d, want %0d",
                                  out_data.sample_out, want.sample_out));
        if (out_data.run_last !== want.run_last)
          flag_mismatch($sformatf("run_last %b, want %b", out_data.run_last, want.run_last));
        if (out_data.stream_end !== want.stream_end)
          flag_mismatch($sformatf("stream_end %b, want %b",
                                  out_data.stream_end, want.stream_end));
      end
    end
  end

  initial begin
    #25ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_defaults();
    test_sample_extremes();
    test_factor_limits();
    test_decimate();
    test_mode_change();
    test_random_streams(300);
    wait_idle(SETTLE_CYCLES);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
